// ===== src/sods_pkg.sv =====
package sods_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int OFF_W        = 9;
    localparam int SEC_W        = 16;
    localparam int BASE_W       = 8;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_BASE    = 2'd0,
        CFG_OUT_BASE   = 2'd1,
        CFG_QUEUE_BASE = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_LOAD  = 2'd2,
        MODE_NONE  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_IMAGE   = 3'd0,
        REG_IN      = 3'd1,
        REG_OUT     = 3'd2,
        REG_QUEUE   = 3'd3,
        REG_OVERLAY = 3'd4
    } region_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_RESP
    } state_t;

    // Result of the tag lookup for the sector under access.
    typedef struct packed {
        logic hit;
        logic full;
    } tag_look_t;

    // Decision taken in the lookup cycle and used in the response cycle.
    typedef struct packed {
        logic    err;
        logic    hit;
        logic    full;
        region_t win;
    } sods_dec_t;

endpackage

// ===== src/sods_ram.sv =====
module sods_ram #(
    parameter int DEPTH = 512,
    parameter int DW    = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== src/sods_tag_table.sv =====
module sods_tag_table #(
    parameter int ENTRIES = 48,
    localparam int EW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int UW     = $clog2(ENTRIES + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [sods_pkg::SEC_W-1:0]  sector,
    input  logic                        alloc,
    output sods_pkg::tag_look_t         look,
    output logic [EW-1:0]               hit_idx,
    output logic [EW-1:0]               alloc_idx
);

    import sods_pkg::*;

    logic [SEC_W-1:0] tag_reg [ENTRIES];
    logic [UW-1:0]    used_reg;
    logic [UW-1:0]    used_next;
    logic [ENTRIES-1:0] match;

    // Tags of allocated entries are unique, so the index is an OR of the matches.
    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            match[i] = (UW'(i) < used_reg) && (tag_reg[i] == sector);
            if (match[i])
            begin
                hit_idx = hit_idx | EW'(i);
            end
        end
        look.hit  = |match;
        look.full = (used_reg == UW'(ENTRIES));
        alloc_idx = look.full ? '0 : used_reg[EW-1:0];
        used_next = (alloc && !look.full) ? used_reg + 1'b1 : used_reg;
    end

    always_ff @(posedge clk)
    begin
        if (alloc)
        begin
            tag_reg[alloc_idx] <= sector;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else
        begin
            used_reg <= used_next;
        end
    end

endmodule

// ===== src/sector_overlay_disk_store.sv =====
// Channel       | Signals                                       | Handshake
// --------------+-----------------------------------------------+------------------------------
// command       | start, busy, mode, sector, byte_offset, wdata | taken when start && !busy
// result        | done, rdata, status, region, evicted          | done high for one cycle
// configuration | cfg_valid, cfg_ready, cfg_index, cfg_wdata    | taken when cfg_valid && cfg_ready
//
// A transaction on the command channel has a lookup state, to match the tag table, decode
// the windows and read the memories, and a write-back state, to modify and write back.
// The next command can be taken during write-back, so busy is high only in the lookup state.
// The result is registered in the write-back cycle. The receiver cannot stall it.
// Reset clears the state machine, done and the table fill count, and sets the configuration
// bases to 0, 4 and 8; the memories are not cleared and need no clearing pass.
module sector_overlay_disk_store #(
    parameter int DISK_SECTORS    = 256,
    parameter int IN_SECTORS      = 4,
    parameter int OUT_SECTORS     = 4,
    parameter int QUEUE_SECTORS   = 4,
    parameter int OVERLAY_ENTRIES = 48
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        mode,
    input  logic [sods_pkg::SEC_W-1:0]        sector,
    input  logic [sods_pkg::OFF_W-1:0]        byte_offset,
    input  logic [7:0]                        wdata,
    output logic                              done,
    output logic [7:0]                        rdata,
    output logic                              status,
    output logic [2:0]                        region,
    output logic                              evicted,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sods_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [sods_pkg::BASE_W-1:0]       cfg_wdata
);

    import sods_pkg::*;

    localparam int IMG_SW = $clog2(DISK_SECTORS);
    localparam int IN_W   = (IN_SECTORS > 1) ? $clog2(IN_SECTORS) : 1;
    localparam int OUT_W  = (OUT_SECTORS > 1) ? $clog2(OUT_SECTORS) : 1;
    localparam int Q_W    = (QUEUE_SECTORS > 1) ? $clog2(QUEUE_SECTORS) : 1;
    localparam int EW     = (OVERLAY_ENTRIES > 1) ? $clog2(OVERLAY_ENTRIES) : 1;

    // Configuration registers.
    logic [BASE_W-1:0] in_base_reg;
    logic [BASE_W-1:0] out_base_reg;
    logic [BASE_W-1:0] queue_base_reg;

    // Command registers, held from acceptance through the write-back cycle.
    mode_t             mode_reg;
    logic [SEC_W-1:0]  sector_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [7:0]        wdata_reg;

    state_t            state_reg;
    state_t            state_next;
    sods_dec_t         dec_reg;
    sods_dec_t         dec_next;
    logic [EW-1:0]     entry_reg;

    logic              accept;
    logic              look_cycle;
    logic              resp_cycle;

    // Result registers.
    logic              done_reg;
    logic [7:0]        rdata_reg;
    logic              status_reg;
    region_t           region_reg;
    logic              evicted_reg;
    logic [7:0]        rdata_next;
    logic              status_next;
    region_t           region_next;
    logic              evicted_next;

    // Window decode.
    logic              in_hit;
    logic              out_hit;
    logic              queue_hit;
    logic [SEC_W-1:0]  in_diff;
    logic [SEC_W-1:0]  out_diff;
    logic [SEC_W-1:0]  queue_diff;

    // Tag table.
    tag_look_t         look;
    logic [EW-1:0]     hit_idx;
    logic [EW-1:0]     alloc_idx;
    logic              tag_alloc;

    // Memory ports.
    logic              img_we;
    logic              in_we;
    logic              out_we;
    logic              queue_we;
    logic              ovl_we;
    logic [7:0]        img_rd;
    logic [7:0]        in_rd;
    logic [7:0]        out_rd;
    logic [7:0]        queue_rd;
    logic [7:0]        ovl_rd;
    logic [SECTOR_BYTES-1:0] vrow_rd;
    logic [SECTOR_BYTES-1:0] vrow_wr;

    assign cfg_ready  = 1'b1;
    assign accept     = start && !busy;
    assign look_cycle = (state_reg == ST_LOOK);
    assign resp_cycle = (state_reg == ST_RESP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg    <= BASE_W'(0);
            out_base_reg   <= BASE_W'(4);
            queue_base_reg <= BASE_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IN_BASE:    in_base_reg    <= cfg_wdata;
                CFG_OUT_BASE:   out_base_reg   <= cfg_wdata;
                CFG_QUEUE_BASE: queue_base_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode_t'(mode);
            sector_reg <= sector;
            off_reg    <= byte_offset;
            wdata_reg  <= wdata;
        end
    end

    // A window covers the sectors from its base up to base plus its length, exclusive.
    // The offset into the window is the low bits of the sector minus the base.
    always_comb
    begin
        in_diff    = sector_reg - SEC_W'(in_base_reg);
        out_diff   = sector_reg - SEC_W'(out_base_reg);
        queue_diff = sector_reg - SEC_W'(queue_base_reg);
        in_hit     = (sector_reg >= SEC_W'(in_base_reg))
                     && ({1'b0, sector_reg} < (17'(in_base_reg) + 17'(IN_SECTORS)));
        out_hit    = (sector_reg >= SEC_W'(out_base_reg))
                     && ({1'b0, sector_reg} < (17'(out_base_reg) + 17'(OUT_SECTORS)));
        queue_hit  = (sector_reg >= SEC_W'(queue_base_reg))
                     && ({1'b0, sector_reg} < (17'(queue_base_reg) + 17'(QUEUE_SECTORS)));
    end

    // The lookup decision. Overlapping windows resolve in the order in, out, queue.
    // The unused mode never reports an error, whatever its sector.
    always_comb
    begin
        dec_next.err  = (mode_reg != MODE_NONE)
                        && ({1'b0, sector_reg} >= 17'(DISK_SECTORS));
        dec_next.hit  = look.hit;
        dec_next.full = look.full;
        if (in_hit)
        begin
            dec_next.win = REG_IN;
        end
        else if (out_hit)
        begin
            dec_next.win = REG_OUT;
        end
        else if (queue_hit)
        begin
            dec_next.win = REG_QUEUE;
        end
        else
        begin
            dec_next.win = REG_IMAGE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (look_cycle)
        begin
            dec_reg   <= dec_next;
            entry_reg <= look.hit ? hit_idx : alloc_idx;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (accept) state_next = ST_LOOK;
            ST_LOOK: state_next = ST_RESP;
            ST_RESP: state_next = accept ? ST_LOOK : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Write enables for the write-back cycle. Nothing is written for an
    // out-of-range sector or for the read and unused modes.
    always_comb
    begin
        busy      = look_cycle;
        img_we    = 1'b0;
        in_we     = 1'b0;
        out_we    = 1'b0;
        queue_we  = 1'b0;
        ovl_we    = 1'b0;
        if (resp_cycle && !dec_reg.err)
        begin
            case (mode_reg)
                MODE_LOAD:  img_we = 1'b1;
                MODE_WRITE:
                begin
                    in_we    = (dec_reg.win == REG_IN);
                    out_we   = (dec_reg.win == REG_OUT);
                    queue_we = (dec_reg.win == REG_QUEUE);
                    ovl_we   = (dec_reg.win == REG_IMAGE);
                end
                default: ;
            endcase
        end
        tag_alloc = ovl_we && !dec_reg.hit;
    end

    // A freshly taken entry starts its byte mask with only this byte set, which
    // also drops whatever mask an evicted sector left behind.
    assign vrow_wr = (dec_reg.hit ? vrow_rd : '0) | (SECTOR_BYTES'(1) << off_reg);

    sods_tag_table #(
        .ENTRIES (OVERLAY_ENTRIES)
    ) u_tags (
        .clk       (clk),
        .rst_n     (rst_n),
        .sector    (sector_reg),
        .alloc     (tag_alloc),
        .look      (look),
        .hit_idx   (hit_idx),
        .alloc_idx (alloc_idx)
    );

    sods_ram #(
        .DEPTH (DISK_SECTORS * SECTOR_BYTES),
        .DW    (8)
    ) u_image (
        .clk   (clk),
        .we    (img_we),
        .waddr ({sector_reg[IMG_SW-1:0], off_reg}),
        .wdata (wdata_reg),
        .raddr ({sector_reg[IMG_SW-1:0], off_reg}),
        .rdata (img_rd)
    );

    sods_ram #(
        .DEPTH (IN_SECTORS * SECTOR_BYTES),
        .DW    (8)
    ) u_in_win (
        .clk   (clk),
        .we    (in_we),
        .waddr ({in_diff[IN_W-1:0], off_reg}),
        .wdata (wdata_reg),
        .raddr ({in_diff[IN_W-1:0], off_reg}),
        .rdata (in_rd)
    );

    sods_ram #(
        .DEPTH (OUT_SECTORS * SECTOR_BYTES),
        .DW    (8)
    ) u_out_win (
        .clk   (clk),
        .we    (out_we),
        .waddr ({out_diff[OUT_W-1:0], off_reg}),
        .wdata (wdata_reg),
        .raddr ({out_diff[OUT_W-1:0], off_reg}),
        .rdata (out_rd)
    );

    sods_ram #(
        .DEPTH (QUEUE_SECTORS * SECTOR_BYTES),
        .DW    (8)
    ) u_queue_win (
        .clk   (clk),
        .we    (queue_we),
        .waddr ({queue_diff[Q_W-1:0], off_reg}),
        .wdata (wdata_reg),
        .raddr ({queue_diff[Q_W-1:0], off_reg}),
        .rdata (queue_rd)
    );

    // Overlay data and masks are read at the matched entry in the lookup cycle
    // and written at the chosen entry in the write-back cycle.
    sods_ram #(
        .DEPTH (OVERLAY_ENTRIES * SECTOR_BYTES),
        .DW    (8)
    ) u_ovl_bytes (
        .clk   (clk),
        .we    (ovl_we),
        .waddr ({entry_reg, off_reg}),
        .wdata (wdata_reg),
        .raddr ({hit_idx, off_reg}),
        .rdata (ovl_rd)
    );

    sods_ram #(
        .DEPTH (OVERLAY_ENTRIES),
        .DW    (SECTOR_BYTES)
    ) u_ovl_mask (
        .clk   (clk),
        .we    (ovl_we),
        .waddr (entry_reg),
        .wdata (vrow_wr),
        .raddr (hit_idx),
        .rdata (vrow_rd)
    );

    // Result formation. Reads use the overlay (unmasked bytes: image), windows, then image.
    always_comb
    begin
        rdata_next   = 8'd0;
        status_next  = 1'b0;
        region_next  = REG_IMAGE;
        evicted_next = 1'b0;
        if (dec_reg.err)
        begin
            status_next = 1'b1;
        end
        else
        begin
            case (mode_reg)
                MODE_READ:
                begin
                    if (dec_reg.hit)
                    begin
                        region_next = REG_OVERLAY;
                        rdata_next  = vrow_rd[off_reg] ? ovl_rd : img_rd;
                    end
                    else
                    begin
                        region_next = dec_reg.win;
                        case (dec_reg.win)
                            REG_IN:    rdata_next = in_rd;
                            REG_OUT:   rdata_next = out_rd;
                            REG_QUEUE: rdata_next = queue_rd;
                            default:   rdata_next = img_rd;
                        endcase
                    end
                end
                MODE_WRITE:
                begin
                    if (dec_reg.win == REG_IMAGE)
                    begin
                        region_next  = REG_OVERLAY;
                        evicted_next = !dec_reg.hit && dec_reg.full;
                    end
                    else
                    begin
                        region_next = dec_reg.win;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= resp_cycle;
        end
    end

    always_ff @(posedge clk)
    begin
        if (resp_cycle)
        begin
            rdata_reg   <= rdata_next;
            status_reg  <= status_next;
            region_reg  <= region_next;
            evicted_reg <= evicted_next;
        end
    end

    assign done    = done_reg;
    assign rdata   = rdata_reg;
    assign status  = status_reg;
    assign region  = region_reg;
    assign evicted = evicted_reg;

endmodule
